[rtl/ctbs_pkg.sv]
// ----------------------------------------------------------------------------
// ctbs_pkg: shared types and constants of the corrected timebase sync block
// Function codes, item and result structs, adjustment thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

package ctbs_pkg;

    typedef enum logic [2:0] {
        FUNC_CONVERT = 3'd0,
        FUNC_MID     = 3'd1,
        FUNC_WRAP    = 3'd2,
        FUNC_SYNC    = 3'd3,
        FUNC_APPLY   = 3'd4,
        FUNC_CLEAR   = 3'd5
    } func_t;

    localparam int unsigned TIME_W = 32;

    // Errors inside this window are applied once the first step is done.
    localparam logic signed [TIME_W-1:0] SYNC_WINDOW  = 32'sd100;
    // Adjustments beyond this magnitude count as a time change.
    localparam logic signed [TIME_W-1:0] CHANGE_LIMIT = 32'sd1000;

    typedef struct packed {
        logic [2:0]               func;
        logic [TIME_W-1:0]        raw_time;
        logic [TIME_W-1:0]        ref_time;
        logic [TIME_W-1:0]        ref_prev_offset;
        logic signed [TIME_W-1:0] adjustment;
    } item_t;

    typedef struct packed {
        logic [TIME_W-1:0]        corrected_time;
        logic                     offset_applied;
        logic                     time_changed;
        logic signed [TIME_W-1:0] sync_error;
    } result_t;

endpackage

`default_nettype wire

[rtl/corrected_timebase_sync.sv]
// ----------------------------------------------------------------------------
// corrected_timebase_sync: corrected microsecond timebase with reference sync
//
// Item channel: item_valid/item_stall with func, raw_time, ref_time,
// ref_prev_offset and adjustment. A transfer happens at a rising edge with
// item_valid high and item_stall low. Every item gives exactly one result on
// the result channel (result_valid/result_stall), in order.
// Configuration: cfg_write with cfg_data loads rate_multiplier; write it only
// while no item is in flight.
// Flow: an item taken at a transfer sits in the input register, is evaluated
// against the offsets there and moves to the result register once that is
// free; its result is then valid and can transfer out. Throughput is one item
// per cycle while the receiver does not stall, set by the single multiply-add
// path from the input register to the result register.
// Reset clears the offsets, arms the pending first step and clears the
// multiplier. While the receiver stalls, the result holds and the input
// register still takes one more item; after that item_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module corrected_timebase_sync
    import ctbs_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic [TIME_W-1:0]        cfg_data,
    input  wire logic                     item_valid,
    output logic                          item_stall,
    input  wire logic [2:0]               func,
    input  wire logic [TIME_W-1:0]        raw_time,
    input  wire logic [TIME_W-1:0]        ref_time,
    input  wire logic [TIME_W-1:0]        ref_prev_offset,
    input  wire logic signed [TIME_W-1:0] adjustment,
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output logic [TIME_W-1:0]             corrected_time,
    output logic                          offset_applied,
    output logic                          time_changed,
    output logic signed [TIME_W-1:0]      sync_error
);

    logic [TIME_W-1:0] rate_multiplier_reg;
    logic              hold_valid_reg;
    item_t             hold_item_reg;
    logic              result_valid_reg;
    result_t           result_reg;
    result_t           result_next;
    logic              out_free;
    logic              fire;
    logic              take;

    assign out_free   = !result_valid_reg || !result_stall;
    assign fire       = hold_valid_reg && out_free;
    assign item_stall = hold_valid_reg && !out_free;
    assign take       = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rate_multiplier_reg <= '0;
        else if (cfg_write)
            rate_multiplier_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                hold_valid_reg <= 1'b1;
            else if (fire)
                hold_valid_reg <= 1'b0;

            if (fire)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // Payload registers: load on transfer, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_item_reg.func            <= func;
            hold_item_reg.raw_time        <= raw_time;
            hold_item_reg.ref_time        <= ref_time;
            hold_item_reg.ref_prev_offset <= ref_prev_offset;
            hold_item_reg.adjustment      <= adjustment;
        end
        if (fire)
            result_reg <= result_next;
    end

    ctbs_engine u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .item            (hold_item_reg),
        .rate_multiplier (rate_multiplier_reg),
        .result          (result_next)
    );

    assign result_valid   = result_valid_reg;
    assign corrected_time = result_reg.corrected_time;
    assign offset_applied = result_reg.offset_applied;
    assign time_changed   = result_reg.time_changed;
    assign sync_error     = result_reg.sync_error;

endmodule

`default_nettype wire

[rtl/ctbs_corrector.sv]
// ----------------------------------------------------------------------------
// ctbs_corrector: raw count to corrected time
// Scales the raw count by the fractional multiplier and adds the offset
// picked by the top bit of the raw count.
// ----------------------------------------------------------------------------
`default_nettype none

module ctbs_corrector
    import ctbs_pkg::*;
(
    input  wire logic [TIME_W-1:0] raw_time,
    input  wire logic [TIME_W-1:0] rate_multiplier,
    input  wire logic [TIME_W-1:0] current_offset,
    input  wire logic [TIME_W-1:0] previous_offset,
    output logic      [TIME_W-1:0] corrected_time
);

    logic [2*TIME_W-1:0] product;
    logic [TIME_W-1:0]   part;
    logic [TIME_W-1:0]   scaled;

    assign product = {{TIME_W{1'b0}}, raw_time} * {{TIME_W{1'b0}}, rate_multiplier};
    assign part    = product[2*TIME_W-1:TIME_W];

    // Top bit of the multiplier selects a pure fractional rate below one.
    assign scaled  = rate_multiplier[TIME_W-1] ? part : raw_time + part;

    assign corrected_time = scaled +
        (raw_time[TIME_W-1] ? previous_offset : current_offset);

endmodule

`default_nettype wire

[rtl/ctbs_engine.sv]
// ----------------------------------------------------------------------------
// ctbs_engine: offset and step state with per-item function decode
// Evaluates one registered item against the offsets and updates them on
// the cycle the item moves to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctbs_engine
    import ctbs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire item_t             item,
    input  wire logic [TIME_W-1:0] rate_multiplier,
    output result_t                result
);

    logic [TIME_W-1:0] current_offset_reg, current_offset_next;
    logic [TIME_W-1:0] previous_offset_reg, previous_offset_next;
    logic              step_pending_reg, step_pending_next;
    logic              hold_armed_reg, hold_armed_next;

    logic [TIME_W-1:0]        corrected;
    logic [TIME_W-1:0]        err;
    logic signed [TIME_W-1:0] adj_val;
    logic                     do_apply;
    logic                     in_window;

    ctbs_corrector u_corrector (
        .raw_time        (item.raw_time),
        .rate_multiplier (rate_multiplier),
        .current_offset  (current_offset_reg),
        .previous_offset (previous_offset_reg),
        .corrected_time  (corrected)
    );

    assign err       = item.ref_time + item.ref_prev_offset - corrected;
    assign in_window = ($signed(err) >= -SYNC_WINDOW) && ($signed(err) <= SYNC_WINDOW);

    always_comb
    begin
        current_offset_next  = current_offset_reg;
        previous_offset_next = previous_offset_reg;
        step_pending_next    = step_pending_reg;
        hold_armed_next      = hold_armed_reg;
        result               = '0;
        do_apply             = 1'b0;
        adj_val              = item.adjustment;

        case (item.func)
            FUNC_CONVERT:
            begin
                result.corrected_time = corrected;
            end
            FUNC_MID:
            begin
                previous_offset_next = current_offset_reg;
            end
            FUNC_WRAP:
            begin
                current_offset_next = current_offset_reg + rate_multiplier;
            end
            FUNC_SYNC:
            begin
                result.corrected_time = corrected;
                result.sync_error     = $signed(err);
                adj_val               = $signed(err);
                if (step_pending_reg)
                begin
                    if ((item.ref_prev_offset != '0) || hold_armed_reg)
                        do_apply = 1'b1;
                    else
                        hold_armed_next = 1'b1;
                end
                else if (in_window)
                begin
                    do_apply = 1'b1;
                end
            end
            FUNC_APPLY:
            begin
                do_apply = 1'b1;
            end
            FUNC_CLEAR:
            begin
                current_offset_next  = '0;
                previous_offset_next = '0;
            end
            default:
            begin
            end
        endcase

        if (do_apply)
        begin
            result.offset_applied = 1'b1;
            result.time_changed   = step_pending_reg || (adj_val < -CHANGE_LIMIT) ||
                                    (adj_val > CHANGE_LIMIT);
            current_offset_next   = current_offset_reg + adj_val;
            previous_offset_next  = previous_offset_reg + adj_val;
            step_pending_next     = 1'b0;
            hold_armed_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_offset_reg  <= '0;
            previous_offset_reg <= '0;
            step_pending_reg    <= 1'b1;
            hold_armed_reg      <= 1'b0;
        end
        else if (fire)
        begin
            current_offset_reg  <= current_offset_next;
            previous_offset_reg <= previous_offset_next;
            step_pending_reg    <= step_pending_next;
            hold_armed_reg      <= hold_armed_next;
        end
    end

    // A held step only exists while the first step is still pending.
    a_held_implies_pending: assert property (@(posedge clk) disable iff (!rst_n)
        hold_armed_reg |-> step_pending_reg)
        else $error("step held flag set after step was taken");

    a_apply_ends_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.offset_applied) |=> (!step_pending_reg && !hold_armed_reg))
        else $error("step state not cleared by applied adjustment");

    a_changed_needs_apply: assert property (@(posedge clk) disable iff (!rst_n)
        result.time_changed |-> result.offset_applied)
        else $error("time change flagged without an adjustment");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (item.func == FUNC_CLEAR)) |=>
            (current_offset_reg == '0 && previous_offset_reg == '0))
        else $error("offsets not cleared");

    a_error_only_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (item.func != FUNC_SYNC) |-> (result.sync_error == '0))
        else $error("sync error reported outside sync");

endmodule

`default_nettype wire
